/* sv/dspf_pkg.sv */
// ---------------------------------------------------------------------------
// dspf_pkg - shared types and helpers for the damped spring point follower
// Coordinate format, commands, register indexes, sequencer states and the
// rounding and saturation helpers used by the datapath.
// ---------------------------------------------------------------------------
package dspf_pkg;

    localparam int COORD_WIDTH = 24;
    localparam int GAIN_WIDTH  = 16;
    localparam int FRAC_GAIN   = 16;
    localparam int FRAC_MASS   = 8;

    // difference, temporary (velocity + accel) and product widths
    localparam int DIFF_WIDTH = COORD_WIDTH + 1;
    localparam int TMP_WIDTH  = COORD_WIDTH + 10;
    localparam int OPB_WIDTH  = GAIN_WIDTH + 1;
    localparam int PROD_WIDTH = TMP_WIDTH + OPB_WIDTH;
    localparam int ACC_WIDTH  = 34;
    localparam int NEAR_BITS  = 16;

    localparam logic [GAIN_WIDTH-1:0] RST_SPRING   = 16'd3932;
    localparam logic [GAIN_WIDTH-1:0] RST_DAMPING  = 16'd45875;
    localparam logic [GAIN_WIDTH-1:0] RST_INV_MASS = 16'd256;
    localparam logic [GAIN_WIDTH-1:0] RST_DEADBAND = 16'd66;

    localparam logic signed [PROD_WIDTH-1:0] SAT_HI =
        PROD_WIDTH'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
    localparam logic signed [PROD_WIDTH-1:0] SAT_LO = -SAT_HI - PROD_WIDTH'(1);

    typedef enum logic [1:0] {
        CMD_TARGET     = 2'd0,
        CMD_ACTIVATE   = 2'd1,
        CMD_DEACTIVATE = 2'd2,
        CMD_CLEAR      = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        REG_SPRING   = 2'd0,
        REG_DAMPING  = 2'd1,
        REG_INV_MASS = 2'd2,
        REG_DEADBAND = 2'd3
    } t_reg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEED,
        ST_SQ_MUL,
        ST_SQ_ACC,
        ST_NEAR,
        ST_K_MUL,
        ST_K_RND,
        ST_M_MUL,
        ST_M_RND,
        ST_D_MUL,
        ST_D_RND,
        ST_P_UPD,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic [1:0]                    command;
        logic signed [COORD_WIDTH-1:0] target_x;
        logic signed [COORD_WIDTH-1:0] target_y;
        logic signed [COORD_WIDTH-1:0] target_z;
    } t_in_item;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] point_x;
        logic signed [COORD_WIDTH-1:0] point_y;
        logic signed [COORD_WIDTH-1:0] point_z;
    } t_out_item;

    // divide by 2^s, round to nearest, ties away from zero
    function automatic logic signed [PROD_WIDTH-1:0] f_rnd(
        input logic signed [PROD_WIDTH-1:0] x,
        input logic [4:0]                   s
    );
        logic signed [PROD_WIDTH-1:0] one;
        logic signed [PROD_WIDTH-1:0] half;
        logic signed [PROD_WIDTH-1:0] t;
        one  = PROD_WIDTH'(1);
        half = one <<< (s - 5'd1);
        t    = x + half - PROD_WIDTH'(x[PROD_WIDTH-1]);
        return t >>> s;
    endfunction

    function automatic logic signed [COORD_WIDTH-1:0] f_sat(
        input logic signed [PROD_WIDTH-1:0] x
    );
        logic signed [PROD_WIDTH-1:0] y;
        if (x > SAT_HI) begin
            y = SAT_HI;
        end else if (x < SAT_LO) begin
            y = SAT_LO;
        end else begin
            y = x;
        end
        return y[COORD_WIDTH-1:0];
    endfunction

endpackage

/* sv/damped_spring_point_follower.sv */
// ---------------------------------------------------------------------------
// damped_spring_point_follower - 3D tracked point chasing target points
// Damped spring update per axis on one shared multiplier, with deadband
// rejection, trail seeding, saturation and an output register.
// ---------------------------------------------------------------------------
//  channel | signals                               | transfer when
//  --------+---------------------------------------+-------------------------
//  in      | i_in_valid, o_in_ready, i_in_data     | i_in_valid & o_in_ready
//  out     | o_out_valid, i_out_ready, o_out_data  | o_out_valid & i_out_ready
//  cfg     | i_cfg_we, i_cfg_index, i_cfg_data     | i_cfg_we
//
//  Commands other than a new target complete in idle. A first target (seed)
//  copies the target; a target inside the deadband stops after the squared
//  distance; a full update runs on the single multiplier: squared distance
//  per axis, then spring, mass and damping products and position add per axis.
//  Reset is synchronous, active low. A stalled output holds the block in its
//  final state until the output register frees up; o_in_ready only in idle.
// ---------------------------------------------------------------------------
module damped_spring_point_follower
    import dspf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_index,
    input  logic [GAIN_WIDTH-1:0] i_cfg_data
);

    localparam logic [1:0] LAST_AXIS = 2'd2;

    t_state r_state, n_state;

    logic [GAIN_WIDTH-1:0] r_spring, r_damping, r_inv_mass, r_deadband;

    logic signed [COORD_WIDTH-1:0] r_pos [3];
    logic signed [COORD_WIDTH-1:0] r_vel [3];
    logic signed [COORD_WIDTH-1:0] r_tgt [3];

    logic                         r_trail, r_active;
    logic [1:0]                   r_axis;
    logic signed [PROD_WIDTH-1:0] r_prod;
    logic signed [TMP_WIDTH-1:0]  r_tmp;
    logic [ACC_WIDTH-1:0]         r_acc;
    logic                         r_far;
    logic                         r_out_valid;
    t_out_item                    r_out;

    logic                         in_xfer, out_free;
    logic signed [DIFF_WIDTH-1:0] d_cur, nd_cur;
    logic                         d_small;
    logic signed [TMP_WIDTH-1:0]  mul_a;
    logic signed [OPB_WIDTH-1:0]  mul_b;
    logic signed [PROD_WIDTH-1:0] prod;
    logic signed [PROD_WIDTH-1:0] rnd_gain, rnd_mass, pos_sum;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign in_xfer     = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign d_cur  = DIFF_WIDTH'(r_pos[r_axis]) - DIFF_WIDTH'(r_tgt[r_axis]);
    assign nd_cur = DIFF_WIDTH'(r_tgt[r_axis]) - DIFF_WIDTH'(r_pos[r_axis]);
    assign d_small = (d_cur[DIFF_WIDTH-1:NEAR_BITS] == '0)
                  || ((d_cur[DIFF_WIDTH-1:NEAR_BITS] == '1)
                      && (d_cur[NEAR_BITS-1:0] != '0));

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            ST_SQ_MUL: begin
                mul_a = TMP_WIDTH'(d_cur);
                mul_b = d_cur[OPB_WIDTH-1:0];
            end
            ST_K_MUL: begin
                mul_a = TMP_WIDTH'(nd_cur);
                mul_b = signed'({1'b0, r_spring});
            end
            ST_M_MUL: begin
                mul_a = r_tmp;
                mul_b = signed'({1'b0, r_inv_mass});
            end
            ST_D_MUL: begin
                mul_a = r_tmp;
                mul_b = signed'({1'b0, r_damping});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod     = PROD_WIDTH'(mul_a) * PROD_WIDTH'(mul_b);
    assign rnd_gain = f_rnd(r_prod, 5'(FRAC_GAIN));
    assign rnd_mass = f_rnd(r_prod, 5'(FRAC_MASS));
    assign pos_sum  = PROD_WIDTH'(r_pos[r_axis]) + PROD_WIDTH'(r_vel[r_axis]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_xfer && (i_in_data.command == CMD_TARGET) && r_active) begin
                    n_state = r_trail ? ST_SQ_MUL : ST_SEED;
                end
            end
            ST_SEED:   n_state = ST_FIN;
            ST_SQ_MUL: n_state = ST_SQ_ACC;
            ST_SQ_ACC: n_state = (r_axis == LAST_AXIS) ? ST_NEAR : ST_SQ_MUL;
            ST_NEAR: begin
                if (!r_far && (r_acc < ACC_WIDTH'(r_deadband))) begin
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_K_MUL;
                end
            end
            ST_K_MUL:  n_state = ST_K_RND;
            ST_K_RND:  n_state = ST_M_MUL;
            ST_M_MUL:  n_state = ST_M_RND;
            ST_M_RND:  n_state = ST_D_MUL;
            ST_D_MUL:  n_state = ST_D_RND;
            ST_D_RND:  n_state = ST_P_UPD;
            ST_P_UPD:  n_state = (r_axis == LAST_AXIS) ? ST_FIN : ST_K_MUL;
            ST_FIN: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spring   <= RST_SPRING;
            r_damping  <= RST_DAMPING;
            r_inv_mass <= RST_INV_MASS;
            r_deadband <= RST_DEADBAND;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_index))
                REG_SPRING:   r_spring   <= i_cfg_data;
                REG_DAMPING:  r_damping  <= i_cfg_data;
                REG_INV_MASS: r_inv_mass <= i_cfg_data;
                REG_DEADBAND: r_deadband <= i_cfg_data;
                default:      r_spring   <= r_spring;
            endcase
        end
    end

    // control flags and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trail     <= 1'b0;
            r_active    <= 1'b1;
            r_out_valid <= 1'b0;
            r_axis      <= '0;
        end else begin
            if ((r_state == ST_FIN) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    r_axis <= '0;
                    if (in_xfer) begin
                        case (t_cmd'(i_in_data.command))
                            CMD_ACTIVATE: r_active <= 1'b1;
                            CMD_DEACTIVATE: begin
                                r_active <= 1'b0;
                                r_trail  <= 1'b0;
                            end
                            CMD_CLEAR:    r_trail <= 1'b0;
                            default:      r_trail <= r_trail;
                        endcase
                    end
                end
                ST_SQ_ACC: r_axis <= (r_axis == LAST_AXIS) ? 2'd0 : r_axis + 2'd1;
                ST_P_UPD:  r_axis <= (r_axis == LAST_AXIS) ? 2'd0 : r_axis + 2'd1;
                ST_FIN: begin
                    if (out_free) begin
                        r_trail <= 1'b1;
                    end
                end
                default:   r_axis <= r_axis;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_pos[i] <= '0;
                r_vel[i] <= '0;
            end
        end else begin
            r_prod <= prod;
            case (r_state)
                ST_IDLE: begin
                    r_tgt[0] <= i_in_data.target_x;
                    r_tgt[1] <= i_in_data.target_y;
                    r_tgt[2] <= i_in_data.target_z;
                    r_acc    <= '0;
                    r_far    <= 1'b0;
                end
                ST_SEED: begin
                    for (int i = 0; i < 3; i++) begin
                        r_pos[i] <= r_tgt[i];
                        r_vel[i] <= '0;
                    end
                end
                ST_SQ_MUL: r_far <= r_far || !d_small;
                ST_SQ_ACC: r_acc <= r_acc + r_prod[ACC_WIDTH-1:0];
                ST_K_RND:  r_tmp <= rnd_gain[TMP_WIDTH-1:0];
                ST_M_RND:  r_tmp <= TMP_WIDTH'(r_vel[r_axis]) + rnd_mass[TMP_WIDTH-1:0];
                ST_D_RND:  r_vel[r_axis] <= f_sat(rnd_gain);
                ST_P_UPD:  r_pos[r_axis] <= f_sat(pos_sum);
                ST_FIN: begin
                    if (out_free) begin
                        r_out.point_x <= r_pos[0];
                        r_out.point_y <= r_pos[1];
                        r_out.point_z <= r_pos[2];
                    end
                end
                default:   r_tmp <= r_tmp;
            endcase
        end
    end

endmodule
